[hdl/fdtd_pkg.sv]
`default_nettype none

package fdtd_pkg;

  // Width of the reported field value and of the probe register.
  localparam int OUT_BITS   = 24;
  localparam int PROBE_BITS = 8;

  localparam logic [PROBE_BITS-1:0] PROBE_RESET = 8'd50;

  // Sequencer phases.
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_E    = 2'd1;
  localparam logic [1:0] PH_OUT  = 2'd2;

  // Strobes broadcast to every cell of the row.
  typedef struct packed {
    logic clear;
    logic upd_h;
    logic upd_e;
  } cell_ctl_t;

endpackage

`default_nettype wire

[hdl/fdtd_cell.sv]
`default_nettype none

module fdtd_cell #(
  parameter int FIELD_BITS = 24,
  parameter bit FIRST      = 1'b0,
  parameter bit LAST       = 1'b0
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire fdtd_pkg::cell_ctl_t          ctl,
  input  wire logic signed [FIELD_BITS-1:0] src,
  input  wire logic signed [FIELD_BITS-1:0] e_right,
  input  wire logic signed [FIELD_BITS-1:0] h_left,
  output logic signed [FIELD_BITS-1:0]      e,
  output logic signed [FIELD_BITS-1:0]      h
);

  localparam int SUM_BITS = FIELD_BITS + 2;

  // The last cell is the wall: its scaled H never leaves zero.
  if (LAST) begin : g_wall
    assign h = '0;
  end else begin : g_h
    logic signed [SUM_BITS-1:0]   h_sum;
    logic signed [FIELD_BITS-1:0] h_sat;
    logic                         h_fits;

    always_comb begin
      h_sum  = {{2{h[FIELD_BITS-1]}}, h} + {{2{e_right[FIELD_BITS-1]}}, e_right}
             - {{2{e[FIELD_BITS-1]}}, e};
      h_fits = (&h_sum[SUM_BITS-1:FIELD_BITS-1]) | ~(|h_sum[SUM_BITS-1:FIELD_BITS-1]);
      h_sat  = h_fits ? h_sum[FIELD_BITS-1:0]
                      : {h_sum[SUM_BITS-1], {(FIELD_BITS-1){~h_sum[SUM_BITS-1]}}};
    end

    always_ff @(posedge clk) begin
      if (rst || ctl.clear) begin
        h <= '0;
      end else if (ctl.upd_h) begin
        h <= h_sat;
      end
    end
  end

  // Cell 0 takes the source sample instead of the curl update.
  if (FIRST) begin : g_src
    always_ff @(posedge clk) begin
      if (rst || ctl.clear) begin
        e <= '0;
      end else if (ctl.upd_e) begin
        e <= src;
      end
    end
  end else begin : g_e
    logic signed [SUM_BITS-1:0]   e_sum;
    logic signed [FIELD_BITS-1:0] e_sat;
    logic                         e_fits;

    always_comb begin
      e_sum  = {{2{e[FIELD_BITS-1]}}, e} + {{2{h[FIELD_BITS-1]}}, h}
             - {{2{h_left[FIELD_BITS-1]}}, h_left};
      e_fits = (&e_sum[SUM_BITS-1:FIELD_BITS-1]) | ~(|e_sum[SUM_BITS-1:FIELD_BITS-1]);
      e_sat  = e_fits ? e_sum[FIELD_BITS-1:0]
                      : {e_sum[SUM_BITS-1], {(FIELD_BITS-1){~e_sum[SUM_BITS-1]}}};
    end

    always_ff @(posedge clk) begin
      if (rst || ctl.clear) begin
        e <= '0;
      end else if (ctl.upd_e) begin
        e <= e_sat;
      end
    end
  end

endmodule

`default_nettype wire

[hdl/fdtd_probe.sv]
`default_nettype none

module fdtd_probe #(
  parameter int CELLS      = 256,
  parameter int FIELD_BITS = 24
) (
  input  wire logic                                  clk,
  input  wire logic                                  load,
  input  wire logic [fdtd_pkg::PROBE_BITS-1:0]       sel,
  input  wire logic signed [FIELD_BITS-1:0]          e_row [CELLS],
  output logic signed [fdtd_pkg::OUT_BITS-1:0]       probe_value
);

  import fdtd_pkg::*;

  localparam int IDX_BITS = $clog2(CELLS);

  logic                         in_range;
  logic [IDX_BITS-1:0]          idx;
  logic signed [FIELD_BITS-1:0] picked;
  logic signed [OUT_BITS-1:0]   conv;

  if (CELLS >= (1 << PROBE_BITS)) begin : g_idx_wide
    assign in_range = 1'b1;
    assign idx      = IDX_BITS'(sel);
  end else begin : g_idx_narrow
    assign in_range = (sel < PROBE_BITS'(CELLS));
    assign idx      = sel[IDX_BITS-1:0];
  end

  assign picked = e_row[idx];

  if (FIELD_BITS > OUT_BITS) begin : g_sat
    logic fits;
    assign fits = (&picked[FIELD_BITS-1:OUT_BITS-1]) | ~(|picked[FIELD_BITS-1:OUT_BITS-1]);
    assign conv = fits ? picked[OUT_BITS-1:0]
                       : {picked[FIELD_BITS-1], {(OUT_BITS-1){~picked[FIELD_BITS-1]}}};
  end else if (FIELD_BITS == OUT_BITS) begin : g_same
    assign conv = picked;
  end else begin : g_ext
    assign conv = {{(OUT_BITS-FIELD_BITS){picked[FIELD_BITS-1]}}, picked};
  end

  always_ff @(posedge clk) begin
    if (load) begin
      probe_value <= in_range ? conv : '0;
    end
  end

endmodule

`default_nettype wire

[hdl/fdtd_1d_yee_step.sv]
// One-dimensional FDTD field engine: a row of CELLS cells, each holding its
// own electric field register and, but the wall cell, a scaled magnetic one.
// Input channel (in_valid / in_stall, fields func and source_sample): each
// request is one tick. func = 1 clears both fields; func = 0 advances one
// time step and forces cell 0 to source_sample.
// Output channel (out_valid / out_stall, field probe_value): one result per
// tick, the electric field at the probe cell after the tick.
// Configuration channel (cfg_valid / cfg_ready, data probe_cell): sets the
// probe cell; cfg_ready is always high. Write it only while the block is idle.
// Timing: H (or, for a clear, both fields) updates at the accept edge, E of
// all cells in the cycle after, and the probe value is registered in PH_OUT
// once the output register is free. in_stall is high in PH_E and PH_OUT, so
// a new tick is accepted only once the last one is through.
// If the result register still holds a stalled result, the engine waits in
// its last phase until the register is taken; a new tick can be accepted
// while that new result sits stalled in the output register.
// Reset clears both field rows, drops out_valid and sets the probe to 50.
`default_nettype none

module fdtd_1d_yee_step #(
  parameter int CELLS      = 256,
  parameter int FIELD_BITS = 24
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic                                func,
  input  wire logic signed [23:0]                  source_sample,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [fdtd_pkg::OUT_BITS-1:0]     probe_value,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [fdtd_pkg::PROBE_BITS-1:0]     probe_cell
);

  import fdtd_pkg::*;

  logic [1:0]                   phase;
  logic                         clr_q;
  logic [PROBE_BITS-1:0]        probe_sel;
  logic signed [FIELD_BITS-1:0] src_q;
  logic signed [FIELD_BITS-1:0] src_conv;
  logic                         accept;
  logic                         load;
  cell_ctl_t                    ctl;
  logic signed [FIELD_BITS-1:0] e_row [CELLS];
  logic signed [FIELD_BITS-1:0] h_row [CELLS];

  assign cfg_ready = 1'b1;
  assign in_stall  = (phase != PH_IDLE);
  assign accept    = in_valid && !in_stall;
  assign load      = (phase == PH_OUT) && (!out_valid || !out_stall);

  always_comb begin
    ctl.clear = accept && func;
    ctl.upd_h = accept && !func;
    ctl.upd_e = (phase == PH_E) && !clr_q;
  end

  // Bring the 24-bit source sample to the field width.
  if (FIELD_BITS > 24) begin : g_src_ext
    assign src_conv = {{(FIELD_BITS-24){source_sample[23]}}, source_sample};
  end else if (FIELD_BITS == 24) begin : g_src_same
    assign src_conv = source_sample;
  end else begin : g_src_sat
    logic fits;
    assign fits = (&source_sample[23:FIELD_BITS-1]) | ~(|source_sample[23:FIELD_BITS-1]);
    assign src_conv = fits ? source_sample[FIELD_BITS-1:0]
                           : {source_sample[23], {(FIELD_BITS-1){~source_sample[23]}}};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      out_valid <= 1'b0;
      probe_sel <= PROBE_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        probe_sel <= probe_cell;
      end
      case (phase)
        PH_IDLE: begin
          if (accept) begin
            phase <= PH_E;
          end
        end
        PH_E: begin
          phase <= PH_OUT;
        end
        PH_OUT: begin
          if (load) begin
            phase <= PH_IDLE;
          end
        end
        default: begin
          phase <= PH_IDLE;
        end
      endcase
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      clr_q <= func;
      src_q <= src_conv;
    end
  end

  for (genvar m = 0; m < CELLS; m++) begin : g_cell
    logic signed [FIELD_BITS-1:0] e_r;
    logic signed [FIELD_BITS-1:0] h_l;

    if (m == CELLS - 1) begin : g_er_wall
      assign e_r = '0;
    end else begin : g_er
      assign e_r = e_row[m+1];
    end

    if (m == 0) begin : g_hl_edge
      assign h_l = '0;
    end else begin : g_hl
      assign h_l = h_row[m-1];
    end

    fdtd_cell #(
      .FIELD_BITS(FIELD_BITS),
      .FIRST     (m == 0),
      .LAST      (m == CELLS - 1)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .ctl    (ctl),
      .src    (src_q),
      .e_right(e_r),
      .h_left (h_l),
      .e      (e_row[m]),
      .h      (h_row[m])
    );
  end

  fdtd_probe #(
    .CELLS     (CELLS),
    .FIELD_BITS(FIELD_BITS)
  ) u_probe (
    .clk        (clk),
    .load       (load),
    .sel        (probe_sel),
    .e_row      (e_row),
    .probe_value(probe_value)
  );

endmodule

`default_nettype wire

[hdl/fdtd_check.sv]
`default_nettype none

module fdtd_check (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [23:0] probe_value
);

  // A stalled result stays put.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(probe_value))
    else $error("stalled result changed or vanished");

  // After an accepted tick the engine is busy through the PH_E and PH_OUT phases.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall ##1 in_stall)
    else $error("input accepted while a tick was still in progress");

  // A new result only appears at the end of a busy period.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a tick in progress");

  // Reset leaves the block idle with no result pending.
  assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

endmodule

bind fdtd_1d_yee_step fdtd_check u_check (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .probe_value(probe_value)
);

`default_nettype wire

[tb/fdtd_tb_pkg.sv]
package fdtd_tb_pkg;

  // Meaning of the func field of a tick request.
  typedef enum logic {
    TICK_STEP  = 1'b0,
    TICK_CLEAR = 1'b1
  } tick_op_e;

endpackage

[tb/fdtd_1d_yee_step_checker.sv]
module fdtd_1d_yee_step_checker (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  input  wire logic                                 in_stall,
  input  wire logic                                 func,
  input  wire logic signed [23:0]                   source_sample,
  input  wire logic                                 out_valid,
  input  wire logic                                 out_stall,
  input  wire logic signed [fdtd_pkg::OUT_BITS-1:0] probe_value,
  input  wire logic                                 cfg_valid,
  input  wire logic                                 cfg_ready,
  input  wire logic [fdtd_pkg::PROBE_BITS-1:0]      probe_cell,
  output int                                        error_count,
  output int                                        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import fdtd_pkg::*;
  import fdtd_tb_pkg::*;

  localparam int CELLS     = 256;
  localparam int FIELD_MAX = 8388607;
  localparam int FIELD_MIN = -8388608;

  logic signed [23:0]         e_field [CELLS];
  logic signed [23:0]         h_field [CELLS];
  logic [PROBE_BITS-1:0]      probe_sel;
  logic signed [OUT_BITS-1:0] probe_expected_q [$];

  initial begin
    error_count = 0;
    pending     = 0;
  end

  function automatic logic signed [23:0] clamp_field(input int v);
    if (v > FIELD_MAX) return 24'sh7FFFFF;
    if (v < FIELD_MIN) return 24'sh800000;
    return v[23:0];
  endfunction

  // Applies one tick to the field copies and returns the field seen at the probe.
  function automatic logic signed [OUT_BITS-1:0] field_after_tick(
    input tick_op_e op, input logic signed [23:0] src);
    int m;
    if (op == TICK_CLEAR) begin
      for (m = 0; m < CELLS; m++) begin
        e_field[m] = '0;
        h_field[m] = '0;
      end
    end else begin
      // The last H cell is the wall and is never updated.
      for (m = 0; m < CELLS - 1; m++)
        h_field[m] = clamp_field(int'(h_field[m]) + int'(e_field[m + 1]) - int'(e_field[m]));
      for (m = 1; m < CELLS; m++)
        e_field[m] = clamp_field(int'(e_field[m]) + int'(h_field[m]) - int'(h_field[m - 1]));
      e_field[0] = src;
    end
    if (probe_sel < CELLS) return e_field[probe_sel];
    return '0;
  endfunction

  always @(posedge clk) begin
    logic signed [OUT_BITS-1:0] want;
    if (rst) begin
      for (int m = 0; m < CELLS; m++) begin
        e_field[m] = '0;
        h_field[m] = '0;
      end
      probe_sel = PROBE_RESET;
      probe_expected_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (probe_expected_q.size() == 0) begin
          $display("%0t unexpected result: expected none, actual probe_value %0d",
                   $time, probe_value);
          error_count++;
        end else begin
          want = probe_expected_q.pop_front();
          if (probe_value !== want) begin
            $display("%0t probe_value mismatch: expected %0d, actual %0d",
                     $time, want, probe_value);
            error_count++;
          end
        end
      end
      if (in_valid && !in_stall)
        probe_expected_q.push_back(field_after_tick(tick_op_e'(func), source_sample));
      if (cfg_valid && cfg_ready)
        probe_sel = probe_cell;
    end
    pending = probe_expected_q.size();
  end

endmodule

[tb/tb_fdtd_1d_yee_step.sv]
module tb_fdtd_1d_yee_step;
  timeunit 1ns;
  timeprecision 1ps;

  import fdtd_pkg::*;
  import fdtd_tb_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 80;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic                        func = TICK_STEP;
  logic signed [23:0]          source_sample = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic signed [OUT_BITS-1:0]  probe_value;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [PROBE_BITS-1:0]       probe_cell = '0;

  int error_count;
  int pending;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int cycle_count    = 0;
  int hold_left      = 0;
  bit hold_request   = 1'b0;

  always #5 clk = ~clk;

  fdtd_1d_yee_step uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .source_sample(source_sample),
    .out_valid(out_valid), .out_stall(out_stall), .probe_value(probe_value),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .probe_cell(probe_cell)
  );

  fdtd_1d_yee_step_checker checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .source_sample(source_sample),
    .out_valid(out_valid), .out_stall(out_stall), .probe_value(probe_value),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .probe_cell(probe_cell),
    .error_count(error_count), .pending(pending)
  );

  // Receiver side: random stalls, or one long hold-off when asked for.
  always @(posedge clk) begin
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Offers one tick request and returns at the edge that accepts it.
  task automatic offer_tick(input tick_op_e op, input logic signed [23:0] sample);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    func          <= op;
    source_sample <= sample;
    do @(posedge clk); while (in_stall);
  endtask

  // Waits until every result is in and the engine has settled, then sets the probe.
  task automatic write_probe(input logic [PROBE_BITS-1:0] probe_idx);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid  <= 1'b1;
    probe_cell <= probe_idx;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_tick_burst(input int count, input int clear_permille);
    tick_op_e           op;
    logic signed [23:0] sample;
    for (int n = 0; n < count; n++) begin
      op = ($urandom_range(999) < clear_permille) ? TICK_CLEAR : TICK_STEP;
      case ($urandom_range(9))
        0: sample = 24'sh7FFFFF;
        1: sample = 24'sh800000;
        2, 3, 4: sample = 24'($urandom);
        default: sample = 24'(int'($urandom_range(8191)) - 4096);
      endcase
      offer_tick(op, sample);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed ticks, first with the probe left at its reset cell.
    offer_tick(TICK_STEP, 24'sh7FFFFF);
    offer_tick(TICK_STEP, 24'sh800000);
    offer_tick(TICK_CLEAR, 24'sh000000);

    // Probe on the source cell: the result is the forced sample itself.
    write_probe(8'd0);
    offer_tick(TICK_STEP, 24'sh000000);
    offer_tick(TICK_STEP, 24'sh000001);
    offer_tick(TICK_STEP, 24'shFFFFFF);
    offer_tick(TICK_STEP, 24'sh7FFFFF);
    offer_tick(TICK_STEP, 24'sh800000);
    offer_tick(TICK_CLEAR, 24'sh5A5A5A);
    offer_tick(TICK_STEP, 24'sh123456);

    // Repeated extremes next to the source drive the updates into saturation.
    write_probe(8'd1);
    repeat (4) offer_tick(TICK_STEP, 24'sh7FFFFF);
    repeat (3) offer_tick(TICK_STEP, 24'sh800000);
    offer_tick(TICK_CLEAR, 24'shA5A5A5);

    write_probe(8'd2);
    offer_tick(TICK_STEP, 24'sh7FFFFF);
    offer_tick(TICK_STEP, 24'sh800000);
    offer_tick(TICK_STEP, 24'sh000000);

    // Slow receiver, busy sender.
    write_probe(8'($urandom_range(3, 40)));
    send_idle_pct  = 9;
    recv_stall_pct = 80;
    run_tick_burst(200, 15);

    // Probe on the wall cell with no clears, long enough for the wave to reach it.
    write_probe(8'd255);
    send_idle_pct  = 80;
    recv_stall_pct = 9;
    run_tick_burst(300, 0);

    // Full rate, with one long hold-off on the result side to back up the engine.
    write_probe(8'($urandom_range(0, 255)));
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 1'b1;
    run_tick_burst(120, 5);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0 && pending == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
